[rtl/ntlm_pkg.sv]
// Package: MD4 constants, step tables and shared types for the NTLM hash core.
package ntlm_pkg;

	localparam logic [31:0] MD4_INIT_A = 32'h67452301;
	localparam logic [31:0] MD4_INIT_B = 32'hefcdab89;
	localparam logic [31:0] MD4_INIT_C = 32'h98badcfe;
	localparam logic [31:0] MD4_INIT_D = 32'h10325476;
	localparam logic [31:0] MD4_K2     = 32'h5a827999;
	localparam logic [31:0] MD4_K3     = 32'h6ed9eba1;
	localparam logic [7:0]  PAD_MARK   = 8'h80;
	localparam logic [5:0]  LAST_STEP  = 6'd47;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} md4_words_t;

	// block handling: plain data, first padding block, length-only block
	typedef enum logic [1:0] {
		PAD_NONE  = 2'd0,
		PAD_FIRST = 2'd1,
		PAD_EXTRA = 2'd2
	} pad_mode_t;

	function automatic logic [3:0] word_order(input logic [5:0] step);
		logic [3:0] i;
		i = step[3:0];
		case (step[5:4])
			2'd0:    word_order = i;
			2'd1:    word_order = {i[1:0], i[3:2]};
			default: word_order = {i[0], i[1], i[2], i[3]};
		endcase
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] step);
		case ({step[5:4], step[1:0]})
			4'b00_00: rot_amount = 5'd3;
			4'b00_01: rot_amount = 5'd7;
			4'b00_10: rot_amount = 5'd11;
			4'b00_11: rot_amount = 5'd19;
			4'b01_00: rot_amount = 5'd3;
			4'b01_01: rot_amount = 5'd5;
			4'b01_10: rot_amount = 5'd9;
			4'b01_11: rot_amount = 5'd13;
			4'b10_00: rot_amount = 5'd3;
			4'b10_01: rot_amount = 5'd9;
			4'b10_10: rot_amount = 5'd11;
			default:  rot_amount = 5'd15;
		endcase
	endfunction

endpackage

[rtl/ntlm_if.sv]
// Interfaces: character input channel and digest output channel.
interface ntlm_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       char_valid;
	logic       last_char;

	modport source (output valid, char_byte, char_valid, last_char, input ready);
	modport sink (input valid, char_byte, char_valid, last_char, output ready);
endinterface

interface ntlm_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_first;
	logic [63:0] digest_second;

	modport source (output valid, digest_first, digest_second, input ready);
	modport sink (input valid, digest_first, digest_second, output ready);
endinterface

[rtl/ntlm_md4_round.sv]
// One MD4 step: new word from a, f(b,c,d), message word and constant, then rotate roles.
module ntlm_md4_round (
	input  logic [5:0]          step,
	input  ntlm_pkg::md4_words_t words,
	input  logic [31:0]         x,
	output ntlm_pkg::md4_words_t next
);

	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] rot;

	always_comb begin
		case (step[5:4])
			2'd0:    f = (words.b & words.c) | (~words.b & words.d);
			2'd1:    f = ((words.b & words.c) | (words.b & words.d) | (words.c & words.d))
				+ ntlm_pkg::MD4_K2;
			default: f = (words.b ^ words.c ^ words.d) + ntlm_pkg::MD4_K3;
		endcase
		sum = words.a + f + x;
		rot = {sum, sum} << ntlm_pkg::rot_amount(step);
		// shift roles so the next target always sits in a
		next.a = words.d;
		next.b = rot[63:32];
		next.c = words.b;
		next.d = words.c;
	end

endmodule

[rtl/ntlm_md4_password_hash_core.sv]
// Top level: NTLM password hash (MD4 over UTF-16LE), one character per beat.
//
// Each input beat carries one 8-bit character, widened to two bytes and packed into
// a 64-byte block held in registers. Beats are taken only while idle. The beat that
// fills a block (every 32nd character) is followed by one load, 48 MD4 steps
// through a single shared round unit at one step per cycle, and one chaining add.
// A beat with last_char set adds one padded block, or two when fewer than nine
// bytes remain in the block, and then the digest is posted.
// The digest sits in an output register; input beats are taken while it waits, and
// only a following digest stalls until it is taken. After each digest the chaining
// values and byte count return to their initial values.
module ntlm_md4_password_hash_core (
	input  logic          clk,
	input  logic          arst_n,
	ntlm_char_if.sink     chars,
	ntlm_digest_if.source digest
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_COMP,
		S_ADD,
		S_DONE
	} state_t;

	state_t               state_q;
	ntlm_pkg::pad_mode_t  pad_q;
	ntlm_pkg::md4_words_t chain_q;
	ntlm_pkg::md4_words_t work_q;
	ntlm_pkg::md4_words_t work_next;
	logic [63:0]          cnt_q;
	logic [5:0]           step_q;
	logic                 last_q;
	logic                 out_valid_q;
	logic [63:0]          out_first_q;
	logic [63:0]          out_second_q;
	logic [31:0]          msg_q [16];
	logic [31:0]          x_word;
	logic [3:0]           x_idx;
	logic [5:0]           pos;
	logic [63:0]          bit_len;
	logic                 len_here;
	logic                 take;

	assign pos     = cnt_q[5:0];
	assign bit_len = {cnt_q[60:0], 3'b000};
	assign take    = chars.valid && chars.ready;
	assign x_idx   = ntlm_pkg::word_order(step_q);

	assign chars.ready          = (state_q == S_IDLE);
	assign digest.valid         = out_valid_q;
	assign digest.digest_first  = out_first_q;
	assign digest.digest_second = out_second_q;

	// padding is applied on the read side; stale words past the marker read as zero
	always_comb begin
		len_here = (pad_q == ntlm_pkg::PAD_EXTRA) ||
			((pad_q == ntlm_pkg::PAD_FIRST) && (pos[5:3] != 3'b111));
		x_word = msg_q[x_idx];
		if (pad_q != ntlm_pkg::PAD_NONE) begin
			if (len_here && (x_idx == 4'd14)) begin
				x_word = bit_len[31:0];
			end else if (len_here && (x_idx == 4'd15)) begin
				x_word = bit_len[63:32];
			end else if (pad_q == ntlm_pkg::PAD_EXTRA) begin
				x_word = '0;
			end else if (x_idx == pos[5:2]) begin
				x_word = pos[1] ? {8'h00, ntlm_pkg::PAD_MARK, msg_q[x_idx][15:0]}
					: {24'h000000, ntlm_pkg::PAD_MARK};
			end else if (x_idx > pos[5:2]) begin
				x_word = '0;
			end
		end
	end

	ntlm_md4_round u_round (
		.step  (step_q),
		.words (work_q),
		.x     (x_word),
		.next  (work_next)
	);

	// block buffer: each character lands as one little-endian halfword
	always_ff @(posedge clk) begin
		if (take && chars.char_valid) begin
			if (pos[1]) begin
				msg_q[pos[5:2]][31:16] <= {8'h00, chars.char_byte};
			end else begin
				msg_q[pos[5:2]][15:0] <= {8'h00, chars.char_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pad_q        <= ntlm_pkg::PAD_NONE;
			chain_q      <= '{ntlm_pkg::MD4_INIT_A, ntlm_pkg::MD4_INIT_B,
				ntlm_pkg::MD4_INIT_C, ntlm_pkg::MD4_INIT_D};
			work_q       <= '0;
			cnt_q        <= '0;
			step_q       <= '0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_first_q  <= '0;
			out_second_q <= '0;
		end else begin
			// S_DONE reloads the output register itself
			if (digest.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						last_q <= chars.last_char;
						if (chars.char_valid) begin
							cnt_q <= cnt_q + 64'd2;
						end
						if (chars.char_valid && (pos == 6'd62)) begin
							state_q <= S_LOAD;
						end else if (chars.last_char) begin
							pad_q   <= ntlm_pkg::PAD_FIRST;
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					work_q  <= chain_q;
					step_q  <= '0;
					state_q <= S_COMP;
				end
				S_COMP: begin
					work_q <= work_next;
					step_q <= step_q + 6'd1;
					if (step_q == ntlm_pkg::LAST_STEP) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					chain_q.a <= chain_q.a + work_q.a;
					chain_q.b <= chain_q.b + work_q.b;
					chain_q.c <= chain_q.c + work_q.c;
					chain_q.d <= chain_q.d + work_q.d;
					if (pad_q == ntlm_pkg::PAD_NONE) begin
						if (last_q) begin
							pad_q   <= ntlm_pkg::PAD_FIRST;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (!len_here) begin
						pad_q   <= ntlm_pkg::PAD_EXTRA;
						state_q <= S_LOAD;
					end else begin
						pad_q   <= ntlm_pkg::PAD_NONE;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || digest.ready) begin
						out_valid_q  <= 1'b1;
						out_first_q  <= {chain_q.b, chain_q.a};
						out_second_q <= {chain_q.d, chain_q.c};
						chain_q      <= '{ntlm_pkg::MD4_INIT_A, ntlm_pkg::MD4_INIT_B,
							ntlm_pkg::MD4_INIT_C, ntlm_pkg::MD4_INIT_D};
						cnt_q        <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// byte count only ever grows by two bytes per character, so it stays even
	a_cnt_even: assert property (@(posedge clk) disable iff (!arst_n) !cnt_q[0])
		else $error("byte count went odd");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP) |-> (step_q <= ntlm_pkg::LAST_STEP))
		else $error("round step out of range");

	a_new_digest_restart: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && (!out_valid_q || digest.ready)) |=>
			(out_valid_q && (cnt_q == 64'd0) && (chain_q.a == ntlm_pkg::MD4_INIT_A)))
		else $error("digest posted without restart of chaining state");

	a_pad_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_q != ntlm_pkg::PAD_NONE) |-> !chars.ready)
		else $error("input taken during padding");
`endif

endmodule
